@@ design/tda_pkg.sv @@
// Shared types and constants for the table distance approximator.
// No dependencies.
package tda_pkg;

    localparam int DIST_BITS = 17;

    typedef logic [DIST_BITS-1:0] dist_t;

endpackage : tda_pkg

@@ design/tda_norm.sv @@
// Normalization: finds the smallest right shift that brings both magnitudes
// below the table size and yields the shifted table indices. Uses tda_pkg.
module tda_norm
    import tda_pkg::*;
#(
    parameter int TABLE_BITS = 4,
    parameter int INPUT_BITS = 16,
    parameter int SHIFT_BITS = 5
)
(
    input  logic [INPUT_BITS-1:0] mag_x,
    input  logic [INPUT_BITS-1:0] mag_y,
    output logic [TABLE_BITS-1:0] idx_x,
    output logic [TABLE_BITS-1:0] idx_y,
    output logic [SHIFT_BITS-1:0] shift
);

    logic [INPUT_BITS-1:0] mag_or;
    logic [SHIFT_BITS-1:0] bit_len;
    logic [INPUT_BITS-1:0] shifted_x;
    logic [INPUT_BITS-1:0] shifted_y;

    assign mag_or = mag_x | mag_y;

    always_comb
    begin
        bit_len = '0;
        for (int i = 0; i < INPUT_BITS; i++)
        begin
            if (mag_or[i])
            begin
                bit_len = SHIFT_BITS'(i + 1);
            end
        end
    end

    always_comb
    begin
        if (bit_len > SHIFT_BITS'(TABLE_BITS))
        begin
            shift = bit_len - SHIFT_BITS'(TABLE_BITS);
        end
        else
        begin
            shift = '0;
        end
    end

    assign shifted_x = mag_x >> shift;
    assign shifted_y = mag_y >> shift;
    assign idx_x     = shifted_x[TABLE_BITS-1:0];
    assign idx_y     = shifted_y[TABLE_BITS-1:0];

endmodule : tda_norm

@@ design/table_distance_approximator.sv @@
// Top level of the table distance approximator: magnitude stage,
// normalization stage (tda_norm) and table lookup into the output register.
// Depends on tda_pkg and tda_norm.
//
//  channel  signals                          direction  width
//  input    in_valid, in_ready, delta_x/y    in         INPUT_BITS each, signed
//  output   out_valid, out_ready, distance   out        17, unsigned
//
// One item is taken every cycle except while the output is stalled.
// The three pipeline stages advance together; a stalled result holds all of them.
// in_ready drops only while the output register is full and out_ready is low.
// Reset clears the stage valid bits; the table is constant logic.
module table_distance_approximator
    import tda_pkg::*;
#(
    parameter int TABLE_BITS = 4,
    parameter int INPUT_BITS = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [INPUT_BITS-1:0] delta_x,
    input  logic signed [INPUT_BITS-1:0] delta_y,
    output logic                         out_valid,
    input  logic                         out_ready,
    output dist_t                        distance
);

    localparam int SHIFT_BITS = $clog2(INPUT_BITS + 1);
    localparam int ENTRY_BITS = TABLE_BITS + 1;
    localparam int ROM_DEPTH  = 2 ** (2 * TABLE_BITS);
    localparam int SPAN_BITS  = ENTRY_BITS + INPUT_BITS;
    localparam int WIDE_BITS  = (SPAN_BITS > DIST_BITS) ? SPAN_BITS : DIST_BITS;
    localparam int MAX_SHIFT  = INPUT_BITS - TABLE_BITS;

    typedef logic [ENTRY_BITS-1:0] rom_t [ROM_DEPTH];

    function automatic rom_t build_rom();
        rom_t rom;
        int   n;
        int   root;
        for (int y = 0; y < 2 ** TABLE_BITS; y++)
        begin
            for (int x = 0; x < 2 ** TABLE_BITS; x++)
            begin
                n    = x * x + y * y;
                root = 0;
                for (int b = 8; b >= 0; b--)
                begin
                    if ((root + (1 << b)) * (root + (1 << b)) <= n)
                    begin
                        root = root + (1 << b);
                    end
                end
                rom[y * (2 ** TABLE_BITS) + x] = ENTRY_BITS'(root);
            end
        end
        return rom;
    endfunction

    localparam rom_t DIST_ROM = build_rom();

    logic                  advance;
    logic                  mag_valid_reg;
    logic [INPUT_BITS-1:0] mag_x_reg;
    logic [INPUT_BITS-1:0] mag_y_reg;
    logic [INPUT_BITS-1:0] mag_x_next;
    logic [INPUT_BITS-1:0] mag_y_next;
    logic                  idx_valid_reg;
    logic [TABLE_BITS-1:0] idx_x_reg;
    logic [TABLE_BITS-1:0] idx_y_reg;
    logic [SHIFT_BITS-1:0] shift_reg;
    logic [TABLE_BITS-1:0] idx_x_next;
    logic [TABLE_BITS-1:0] idx_y_next;
    logic [SHIFT_BITS-1:0] shift_next;
    logic                  out_valid_reg;
    dist_t                 distance_reg;
    dist_t                 distance_next;
    logic [ENTRY_BITS-1:0] entry;
    logic [WIDE_BITS-1:0]  wide_dist;

    assign advance   = !out_valid_reg || out_ready;
    assign in_ready  = advance;
    assign out_valid = out_valid_reg;
    assign distance  = distance_reg;

    assign mag_x_next = delta_x[INPUT_BITS-1] ? (~delta_x + 1'b1) : delta_x;
    assign mag_y_next = delta_y[INPUT_BITS-1] ? (~delta_y + 1'b1) : delta_y;

    tda_norm #(
        .TABLE_BITS (TABLE_BITS),
        .INPUT_BITS (INPUT_BITS),
        .SHIFT_BITS (SHIFT_BITS)
    ) u_norm (
        .mag_x (mag_x_reg),
        .mag_y (mag_y_reg),
        .idx_x (idx_x_next),
        .idx_y (idx_y_next),
        .shift (shift_next)
    );

    assign entry         = DIST_ROM[{idx_y_reg, idx_x_reg}];
    assign wide_dist     = WIDE_BITS'(entry) << shift_reg;
    assign distance_next = wide_dist[DIST_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_valid_reg <= 1'b0;
            idx_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            mag_valid_reg <= in_valid;
            idx_valid_reg <= mag_valid_reg;
            out_valid_reg <= idx_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mag_x_reg    <= mag_x_next;
            mag_y_reg    <= mag_y_next;
            idx_x_reg    <= idx_x_next;
            idx_y_reg    <= idx_y_next;
            shift_reg    <= shift_next;
            distance_reg <= distance_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> mag_valid_reg)
        else $error("accepted item missing from magnitude stage");

    assert property (@(posedge clk) disable iff (!rst_n)
        mag_valid_reg && advance |=> idx_valid_reg)
        else $error("magnitude stage item lost");

    assert property (@(posedge clk) disable iff (!rst_n)
        idx_valid_reg && !advance |=> idx_valid_reg && $stable(idx_x_reg)
            && $stable(idx_y_reg) && $stable(shift_reg))
        else $error("stalled index stage changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        idx_valid_reg |-> shift_reg <= SHIFT_BITS'(MAX_SHIFT))
        else $error("normalization shift out of range");

endmodule : table_distance_approximator

@@ tb/sv/tb_table_distance_approximator.sv @@
// Testbench for table_distance_approximator: directed and random vectors checked
// against a built-in distance predictor, with random stalls on both channels.
// Depends on tda_pkg and the table_distance_approximator RTL.
`timescale 1ns / 100ps

module tb_table_distance_approximator
    import tda_pkg::*;
;

    localparam int DELTA_BITS   = 16;
    localparam int TABLE_LIMIT  = 16;
    localparam int LATENCY      = 3;
    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 7;

    typedef logic signed [DELTA_BITS-1:0] delta_t;

    logic   clk;
    logic   rst_n;
    logic   in_valid;
    logic   in_ready;
    delta_t delta_x;
    delta_t delta_y;
    logic   out_valid;
    logic   out_ready;
    dist_t  distance;

    dist_t  expected_distances[$];
    int     error_count;
    int     send_idle_pct;
    int     recv_idle_pct;
    int     hold_request;

    table_distance_approximator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .delta_x   (delta_x),
        .delta_y   (delta_y),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .distance  (distance)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        #(5_000_000);
        $display("table_distance_approximator: mismatch");
        $finish;
    end

    function automatic dist_t approx_distance(delta_t dx, delta_t dy);
        logic [DELTA_BITS:0] mag_x;
        logic [DELTA_BITS:0] mag_y;
        int unsigned         shift;
        int unsigned         xs;
        int unsigned         ys;
        int unsigned         sum;
        int unsigned         root;
        int unsigned         trial;
        mag_x = dx[DELTA_BITS-1] ? (DELTA_BITS+1)'((1 << DELTA_BITS) - {1'b0, dx})
                                 : {1'b0, dx};
        mag_y = dy[DELTA_BITS-1] ? (DELTA_BITS+1)'((1 << DELTA_BITS) - {1'b0, dy})
                                 : {1'b0, dy};
        shift = 0;
        while (((mag_x | mag_y) >> shift) >= TABLE_LIMIT)
            shift++;
        xs   = 32'(mag_x >> shift);
        ys   = 32'(mag_y >> shift);
        sum  = xs * xs + ys * ys;
        root = 0;
        for (int b = 15; b >= 0; b--)
        begin
            trial = root | (1 << b);
            if (trial * trial <= sum)
                root = trial;
        end
        return dist_t'(root << shift);
    endfunction

    // Random component of random bit length, so every normalization shift shows up.
    function automatic delta_t random_delta();
        int unsigned len;
        delta_t      value;
        len = $urandom_range(DELTA_BITS, 0);
        if (len == DELTA_BITS)
            value = delta_t'($urandom);
        else
        begin
            value = delta_t'($urandom & ((1 << len) - 1));
            if ($urandom_range(1, 0))
                value = -value;
        end
        return value;
    endfunction

    task automatic send_vector(delta_t dx, delta_t dy);
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        delta_x  <= dx;
        delta_y  <= dy;
        do
            @(posedge clk);
        while (!in_ready);
        expected_distances.push_back(approx_distance(dx, dy));
    endtask

    // Receiver: random stalls, plus a long hold-off on request.
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_distances.size() == 0)
            begin
                $error("distance: no item expected, got %0d", distance);
                error_count++;
            end
            else
            begin
                dist_t want;
                want = expected_distances.pop_front();
                if (distance !== want)
                begin
                    $error("distance: expected %0d, got %0d", want, distance);
                    error_count++;
                end
            end
        end
    end

    task automatic test_directed();
        delta_t cases[][2];
        send_idle_pct = 0;
        recv_idle_pct = 0;
        cases = '{
            '{16'sd0, 16'sd0},          '{16'sd1, 16'sd0},
            '{16'sd0, -16'sd1},         '{-16'sd1, -16'sd1},
            '{16'sd15, 16'sd15},        '{-16'sd15, 16'sd15},
            '{16'sd16, 16'sd0},         '{16'sd0, 16'sd16},
            '{16'sd31, 16'sd17},        '{16'sd32767, 16'sd32767},
            '{-16'sd32768, -16'sd32768}, '{-16'sd32768, 16'sd0},
            '{16'sd0, -16'sd32768},     '{16'sd32767, -16'sd32768},
            '{-16'sd32767, 16'sd1},     '{16'sd4095, 16'sd4096},
            '{16'sd255, -16'sd256},     '{16'sd12, 16'sd5},
            '{16'sd3, 16'sd4},          '{-16'sd30000, 16'sd20000},
            '{16'h5555, 16'h2AAA},      '{16'sd1024, 16'sd1}
        };
        foreach (cases[i])
            send_vector(cases[i][0], cases[i][1]);
    endtask

    task automatic test_random_traffic(int sender_pct, int receiver_pct, int count);
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        repeat (count)
            send_vector(random_delta(), random_delta());
    endtask

    task automatic test_output_stall();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 60;
        repeat (40)
            send_vector(random_delta(), random_delta());
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_distances.size() != 0)
            @(posedge clk);
        repeat (LATENCY * 4)
            @(posedge clk);
    endtask

    initial
    begin
        error_count   = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        delta_x       = '0;
        delta_y       = '0;
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_traffic(30, 83, 430);
        test_random_traffic(83, 30, 430);
        test_random_traffic(0, 0, 430);
        test_output_stall();
        drain_results();

        if (error_count == 0 && expected_distances.size() == 0)
            $display("table_distance_approximator: match");
        else
            $display("table_distance_approximator: mismatch");
        $finish;
    end

endmodule
